@@ hdl/ibl_pkg.sv @@
`timescale 1ns / 1ps

package ibl_pkg;

    // Default list capacity
    localparam int CAPACITY_DEF = 64;

    // Request kinds
    localparam logic [2:0] REQ_READ    = 3'd0;
    localparam logic [2:0] REQ_REPLACE = 3'd1;
    localparam logic [2:0] REQ_INSERT  = 3'd2;
    localparam logic [2:0] REQ_REMOVE  = 3'd3;
    localparam logic [2:0] REQ_ORDERED = 3'd4;
    localparam logic [2:0] REQ_CLEAR   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // What every cell does in an update
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_SET  = 2'd1,
        CELL_INS  = 2'd2,
        CELL_DEL  = 2'd3
    } t_cell_op;

    // Command broadcast along the row of cells
    typedef struct packed {
        t_cell_op   op;
        logic [7:0] value;
    } t_cell_cmd;

endpackage

@@ hdl/ibl_cell.sv @@
`timescale 1ns / 1ps

// One list slot. The mask bits mark the slots at or after the edit point.
module ibl_cell (
    input  logic               i_clk,
    input  ibl_pkg::t_cell_cmd i_cmd,
    input  logic               i_mask,
    input  logic               i_prev_mask,
    input  logic [7:0]         i_prev_byte,
    input  logic [7:0]         i_next_byte,
    output logic [7:0]         o_byte,
    output logic               o_ge
);

    logic [7:0] r_entry;
    logic [7:0] n_entry;

    // New byte goes before this entry if it is not greater
    assign o_ge   = (i_cmd.value <= r_entry);
    assign o_byte = r_entry;

    // Per-slot update: shift up, shift down or write at the edit point
    always_comb begin
        n_entry = r_entry;
        unique case (i_cmd.op)
            ibl_pkg::CELL_HOLD: n_entry = r_entry;
            ibl_pkg::CELL_SET: begin
                if (i_mask && !i_prev_mask) n_entry = i_cmd.value;
            end
            ibl_pkg::CELL_INS: begin
                if (i_prev_mask) n_entry = i_prev_byte;
                else if (i_mask) n_entry = i_cmd.value;
            end
            ibl_pkg::CELL_DEL: begin
                if (i_mask) n_entry = i_next_byte;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ hdl/ibl_ctrl.sv @@
`timescale 1ns / 1ps

// Request capture, status decode, edit-point mask, count and result register.
module ibl_ctrl #(
    parameter int CAPACITY = ibl_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  logic [2:0]                       i_req_type,
    input  logic [$clog2(CAPACITY+1)-1:0]    i_req_pos,
    input  logic [7:0]                       i_req_val,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output logic [7:0]                       o_res_byte,
    output logic [1:0]                       o_res_status,
    output logic [$clog2(CAPACITY+1)-1:0]    o_res_count,
    input  logic [CAPACITY-1:0][7:0]         i_bytes,
    input  logic [CAPACITY-1:0]              i_ge,
    output ibl_pkg::t_cell_cmd               o_cmd,
    output logic [CAPACITY-1:0]              o_mask
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state         r_state;
    logic [2:0]     r_type;
    logic [PW-1:0]  r_pos;
    logic [7:0]     r_val;
    logic [PW-1:0]  r_count;
    logic [PW-1:0]  n_count;
    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic [1:0]     r_out_status;
    logic [PW-1:0]  r_out_count;

    logic           w_go;
    logic           w_empty;
    logic           w_full;
    logic           w_inrange;
    logic [1:0]     w_status;
    logic [7:0]     w_rd;
    logic [CAPACITY-1:0] w_below;
    logic [CAPACITY-1:0] w_idx_mask;
    logic [CAPACITY-1:0] w_ge_full;
    logic [CAPACITY-1:0] w_ord_mask;

    // Execute once the result register has room
    assign w_go        = (r_state == S_EXEC) && (!r_out_valid || i_res_ready);
    assign o_req_ready = (r_state == S_IDLE);

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count >= PW'(CAPACITY));
    assign w_inrange = (r_pos < r_count);

    // Per-slot occupancy and index compare
    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        localparam logic [PW-1:0] K = PW'(g);
        assign w_below[g]    = (K < r_count);
        assign w_idx_mask[g] = (K >= r_pos);
    end

    // Ordered insert point: first occupied slot not below the byte, else count.
    // x | -x sets every bit from the lowest set bit upward.
    assign w_ge_full  = i_ge | ~w_below;
    assign w_ord_mask = w_ge_full | (~w_ge_full + {{(CAPACITY-1){1'b0}}, 1'b1});

    assign o_mask = (r_type == ibl_pkg::REQ_ORDERED) ? w_ord_mask : w_idx_mask;

    // Status decode
    always_comb begin
        w_status = ibl_pkg::ST_OK;
        unique case (r_type)
            ibl_pkg::REQ_READ, ibl_pkg::REQ_REPLACE, ibl_pkg::REQ_REMOVE: begin
                if (w_empty)         w_status = ibl_pkg::ST_EMPTY;
                else if (!w_inrange) w_status = ibl_pkg::ST_RANGE;
            end
            ibl_pkg::REQ_INSERT: begin
                if (r_pos > r_count) w_status = ibl_pkg::ST_RANGE;
                else if (w_full)     w_status = ibl_pkg::ST_FULL;
            end
            ibl_pkg::REQ_ORDERED: begin
                if (w_full) w_status = ibl_pkg::ST_FULL;
            end
            default: w_status = ibl_pkg::ST_OK;
        endcase
    end

    // Cell command, next count and read data
    always_comb begin
        o_cmd.op    = ibl_pkg::CELL_HOLD;
        o_cmd.value = r_val;
        n_count     = r_count;
        w_rd        = '0;
        if (w_status == ibl_pkg::ST_OK) begin
            unique case (r_type)
                ibl_pkg::REQ_READ: w_rd = i_bytes[r_pos[IW-1:0]];
                ibl_pkg::REQ_REPLACE: o_cmd.op = ibl_pkg::CELL_SET;
                ibl_pkg::REQ_INSERT, ibl_pkg::REQ_ORDERED: begin
                    o_cmd.op = ibl_pkg::CELL_INS;
                    n_count  = r_count + PW'(1);
                end
                ibl_pkg::REQ_REMOVE: begin
                    o_cmd.op = ibl_pkg::CELL_DEL;
                    n_count  = r_count - PW'(1);
                end
                ibl_pkg::REQ_CLEAR: n_count = '0;
                default: n_count = r_count;
            endcase
        end
        if (!w_go) o_cmd.op = ibl_pkg::CELL_HOLD;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_req_valid) r_state <= S_EXEC;
                S_EXEC: if (w_go) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (w_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_type <= i_req_type;
            r_pos  <= i_req_pos;
            r_val  <= i_req_val;
        end
        if (w_go) begin
            r_out_byte   <= w_rd;
            r_out_status <= w_status;
            r_out_count  <= n_count;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_res_byte   = r_out_byte;
    assign o_res_status = r_out_status;
    assign o_res_count  = r_out_count;

endmodule

@@ hdl/indexed_byte_list_core.sv @@
`timescale 1ns / 1ps
// A request is first captured, then all cells update together as the result is registered.
// A new request is taken only after that update; the update waits while the result
// register still holds a result the output side has not taken.
// Each edit is one parallel shift over the row of cells, whatever the list length.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending result.

module indexed_byte_list_core #(
    parameter int CAPACITY = ibl_pkg::CAPACITY_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // position, byte_value; zero padded
    input  logic [((8+$clog2(CAPACITY+1)+7)/8)*8-1:0] s_axis_tdata,
    // req_type
    input  logic [2:0]                               s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // read_byte, entry_count; zero padded
    output logic [((8+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [1:0]                               m_axis_tuser
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int DW = ((8 + PW + 7) / 8) * 8;

    ibl_pkg::t_cell_cmd          w_cmd;
    logic [CAPACITY-1:0]         w_mask;
    logic [CAPACITY-1:0]         w_ge;
    logic [CAPACITY-1:0][7:0]    w_bytes;
    logic [7:0]                  w_res_byte;
    logic [PW-1:0]               w_res_count;

    ibl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_req_type   (s_axis_tuser),
        .i_req_pos    (s_axis_tdata[PW-1:0]),
        .i_req_val    (s_axis_tdata[PW+7:PW]),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res_byte   (w_res_byte),
        .o_res_status (m_axis_tuser),
        .o_res_count  (w_res_count),
        .i_bytes      (w_bytes),
        .i_ge         (w_ge),
        .o_cmd        (w_cmd),
        .o_mask       (w_mask)
    );

    // Row of cells; each sees its neighbors' bytes and the mask bit below it
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic       w_prev_mask;
        logic [7:0] w_prev_byte;
        logic [7:0] w_next_byte;

        if (g == 0) begin : g_first
            assign w_prev_mask = 1'b0;
            assign w_prev_byte = w_bytes[g];
        end else begin : g_mid
            assign w_prev_mask = w_mask[g-1];
            assign w_prev_byte = w_bytes[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_next_byte = w_bytes[g];
        end else begin : g_inner
            assign w_next_byte = w_bytes[g+1];
        end

        ibl_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_mask      (w_mask[g]),
            .i_prev_mask (w_prev_mask),
            .i_prev_byte (w_prev_byte),
            .i_next_byte (w_next_byte),
            .o_byte      (w_bytes[g]),
            .o_ge        (w_ge[g])
        );
    end

    assign m_axis_tdata = DW'({w_res_count, w_res_byte});

endmodule

@@ verif/tb_indexed_byte_list_core.sv @@
`timescale 1ns / 1ps

module tb_indexed_byte_list_core;

    localparam int CAP         = ibl_pkg::CAPACITY_DEF;
    localparam int TDATA_W     = ((8 + $clog2(CAP + 1) + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;

    // Request kinds the block must ignore
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [1:0] status;
        logic [6:0] entry_count;
    } t_list_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;   // position, byte_value, zero pad
    logic [2:0]         s_axis_tuser = '0;   // req_type
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // read_byte, entry_count, zero pad
    logic [1:0]         m_axis_tuser;        // status

    // Shadow copy of the list contents
    logic [7:0]   shadow_bytes [CAP];
    int           shadow_count = 0;
    t_list_answer owed_answers [$];

    int          error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    logic        sink_hold = 1'b0;
    int          fill_target = CAP / 2;

    indexed_byte_list_core #(.CAPACITY(CAP)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Apply one request to the shadow list and return the answer it owes
    function automatic t_list_answer apply_to_shadow_list(input logic [2:0] kind,
                                                          input int pos,
                                                          input logic [7:0] val);
        t_list_answer ans;
        int slot;
        ans = '0;
        ans.status = ibl_pkg::ST_OK;
        slot = 0;
        case (kind)
            ibl_pkg::REQ_READ, ibl_pkg::REQ_REPLACE, ibl_pkg::REQ_REMOVE: begin
                if (shadow_count == 0) begin
                    ans.status = ibl_pkg::ST_EMPTY;
                end else if (pos >= shadow_count) begin
                    ans.status = ibl_pkg::ST_RANGE;
                end else if (kind == ibl_pkg::REQ_READ) begin
                    ans.read_byte = shadow_bytes[pos];
                end else if (kind == ibl_pkg::REQ_REPLACE) begin
                    shadow_bytes[pos] = val;
                end else begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_bytes[i] = shadow_bytes[i+1];
                    shadow_count--;
                end
            end
            ibl_pkg::REQ_INSERT, ibl_pkg::REQ_ORDERED: begin
                if (kind == ibl_pkg::REQ_INSERT && pos > shadow_count) begin
                    ans.status = ibl_pkg::ST_RANGE;
                end else if (shadow_count >= CAP) begin
                    ans.status = ibl_pkg::ST_FULL;
                end else begin
                    if (kind == ibl_pkg::REQ_INSERT) begin
                        slot = pos;
                    end else begin
                        // first entry not less than the new byte, else append
                        slot = shadow_count;
                        for (int i = shadow_count - 1; i >= 0; i--)
                            if (val <= shadow_bytes[i])
                                slot = i;
                    end
                    for (int i = shadow_count; i > slot; i--)
                        shadow_bytes[i] = shadow_bytes[i-1];
                    shadow_bytes[slot] = val;
                    shadow_count++;
                end
            end
            ibl_pkg::REQ_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
            end
        endcase
        ans.entry_count = shadow_count[6:0];
        return ans;
    endfunction

    // Offer one request, wait for it to be taken, then log its answer
    task automatic send_request(input logic [2:0] kind, input logic [6:0] pos,
                                input logic [7:0] val);
        if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(TDATA_W-15){1'b0}}, val, pos};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        owed_answers.push_back(apply_to_shadow_list(kind, pos, val));
    endtask

    // Drop valid and wait until every answer is back
    task automatic drain_answers();
        s_axis_tvalid <= 1'b0;
        while (owed_answers.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus long hold-offs on demand
    always @(posedge i_clk) begin
        if (sink_hold)
            m_axis_tready <= 1'b0;
        else if (sink_idle_pct == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Answer checker
    always @(posedge i_clk) begin
        t_list_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (owed_answers.size() == 0) begin
                $display("%0t: unexpected answer, read_byte %0d status %0d count %0d",
                         $time, m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[14:8]);
                error_count = error_count + 1;
            end else begin
                want = owed_answers.pop_front();
                if (m_axis_tdata[7:0] !== want.read_byte) begin
                    $display("%0t: read_byte expected %0d, got %0d",
                             $time, want.read_byte, m_axis_tdata[7:0]);
                    error_count = error_count + 1;
                end
                if (m_axis_tuser !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, m_axis_tuser);
                    error_count = error_count + 1;
                end
                if (m_axis_tdata[14:8] !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d, got %0d",
                             $time, want.entry_count, m_axis_tdata[14:8]);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // Edge cases on a short list: empty, bounds, ordering ties, ignored kinds
    task automatic test_edge_cases();
        send_request(ibl_pkg::REQ_READ,    7'd0,   8'h00);
        send_request(ibl_pkg::REQ_REPLACE, 7'd0,   8'h12);
        send_request(ibl_pkg::REQ_REMOVE,  7'd0,   8'h00);
        send_request(ibl_pkg::REQ_INSERT,  7'd1,   8'h34);
        send_request(ibl_pkg::REQ_ORDERED, 7'd0,   8'h80);
        send_request(ibl_pkg::REQ_ORDERED, 7'd127, 8'hFF);
        send_request(ibl_pkg::REQ_ORDERED, 7'd0,   8'h00);
        send_request(ibl_pkg::REQ_ORDERED, 7'd0,   8'h80);
        send_request(ibl_pkg::REQ_INSERT,  7'd4,   8'h55);
        send_request(ibl_pkg::REQ_INSERT,  7'd0,   8'hAA);
        send_request(ibl_pkg::REQ_READ,    7'd127, 8'h00);
        send_request(ibl_pkg::REQ_READ,    7'd6,   8'h00);
        send_request(ibl_pkg::REQ_REPLACE, 7'd5,   8'hFF);
        send_request(ibl_pkg::REQ_READ,    7'd5,   8'hFF);
        send_request(ibl_pkg::REQ_REMOVE,  7'd0,   8'h00);
        send_request(ibl_pkg::REQ_REMOVE,  7'd4,   8'h00);
        send_request(ibl_pkg::REQ_REMOVE,  7'd7,   8'h00);
        send_request(ibl_pkg::REQ_INSERT,  7'd127, 8'h01);
        send_request(REQ_SPARE6,           7'd0,   8'hFF);
        send_request(REQ_SPARE7,           7'd127, 8'h00);
        send_request(ibl_pkg::REQ_READ,    7'd0,   8'h00);
        send_request(ibl_pkg::REQ_CLEAR,   7'd0,   8'h00);
        send_request(ibl_pkg::REQ_READ,    7'd0,   8'h00);
        send_request(ibl_pkg::REQ_CLEAR,   7'd127, 8'hFF);
        drain_answers();
    endtask

    // Fill to capacity, then probe the full list
    task automatic test_full_list();
        while (shadow_count < CAP) begin
            if ($urandom_range(1))
                send_request(ibl_pkg::REQ_ORDERED, 7'($urandom_range(127)),
                             8'($urandom_range(255)));
            else
                send_request(ibl_pkg::REQ_INSERT, 7'($urandom_range(shadow_count)),
                             8'($urandom_range(255)));
        end
        send_request(ibl_pkg::REQ_INSERT,  7'(CAP + 1), 8'h11);   // range wins over full
        send_request(ibl_pkg::REQ_INSERT,  7'(CAP),     8'h22);
        send_request(ibl_pkg::REQ_INSERT,  7'd0,        8'h33);
        send_request(ibl_pkg::REQ_ORDERED, 7'd0,        8'h00);
        send_request(ibl_pkg::REQ_READ,    7'(CAP - 1), 8'h00);
        send_request(ibl_pkg::REQ_READ,    7'(CAP),     8'h00);
        send_request(ibl_pkg::REQ_REPLACE, 7'(CAP - 1), 8'hFF);
        send_request(ibl_pkg::REQ_REMOVE,  7'(CAP - 1), 8'h00);
        send_request(ibl_pkg::REQ_INSERT,  7'(CAP - 1), 8'h7F);
        send_request(ibl_pkg::REQ_REMOVE,  7'd0,        8'h00);
        send_request(ibl_pkg::REQ_READ,    7'd0,        8'h00);
        drain_answers();
    endtask

    // Random traffic; the fill level wanders toward a moving target
    task automatic test_random_traffic(input int n_items);
        logic [2:0] kind;
        logic [6:0] pos;
        int         r;
        int         sub;
        for (int n = 0; n < n_items; n++) begin
            if (n % 30 == 0)
                fill_target = ($urandom_range(3) == 0) ? CAP : $urandom_range(CAP);
            r = $urandom_range(99);
            sub = $urandom_range(67);
            if (r < 3)
                kind = $urandom_range(1) ? REQ_SPARE6 : REQ_SPARE7;
            else if (r < 5)
                kind = ibl_pkg::REQ_CLEAR;
            else if (r < 20)
                kind = ibl_pkg::REQ_READ;
            else if (r < 32)
                kind = ibl_pkg::REQ_REPLACE;
            else if (shadow_count < fill_target)
                kind = (sub < 30) ? ibl_pkg::REQ_INSERT :
                       (sub < 58) ? ibl_pkg::REQ_ORDERED : ibl_pkg::REQ_REMOVE;
            else
                kind = (sub < 40) ? ibl_pkg::REQ_REMOVE :
                       (sub < 54) ? ibl_pkg::REQ_INSERT : ibl_pkg::REQ_ORDERED;

            if ($urandom_range(9) == 0)
                pos = 7'($urandom_range(127));
            else if (kind == ibl_pkg::REQ_INSERT)
                pos = 7'($urandom_range(shadow_count));
            else
                pos = 7'((shadow_count == 0) ? 0 : $urandom_range(shadow_count - 1));
            send_request(kind, pos, 8'($urandom_range(255)));
        end
        drain_answers();
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        fork
            begin
                sink_hold <= 1'b1;
                repeat (300) @(posedge i_clk);
                sink_hold <= 1'b0;
            end
        join_none
        for (int n = 0; n < 40; n++)
            send_request(($urandom_range(1)) ? ibl_pkg::REQ_ORDERED : ibl_pkg::REQ_READ,
                         7'($urandom_range(shadow_count)), 8'($urandom_range(255)));
        drain_answers();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 38;
        sink_idle_pct <= 77;
        test_edge_cases();
        test_full_list();
        test_random_traffic(250);

        src_idle_pct = 77;
        sink_idle_pct <= 38;
        test_random_traffic(250);

        src_idle_pct = 0;
        sink_idle_pct <= 0;
        test_output_backpressure();
        test_random_traffic(200);

        repeat (10) @(posedge i_clk);
        if (error_count == 0 && owed_answers.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
